// ----- hdl/ssg_pkg.sv -----
// shared types, constants and sine table function for the stepped sine sweep generator
`timescale 1ns / 1ps

package ssg_pkg;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int INCR_W        = 32;
   localparam int COUNT_W       = 24;
   localparam int STEP_W        = 16;
   localparam int MODE_W        = 2;
   localparam int VOLUME_W      = 15;
   localparam int MAG_W         = 15;
   localparam int SAMPLE_W      = 16;
   localparam int PRODUCT_W     = VOLUME_W + MAG_W;

   localparam logic [COUNT_W-1:0]  SAMPLES_PER_STEP_RESET = 24'd44100;
   localparam logic [STEP_W-1:0]   STEP_COUNT_RESET       = 16'd1;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET           = 15'd500;

   localparam int MUTE_RIGHT_BIT = 0;
   localparam int MUTE_LEFT_BIT  = 1;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned FULL_SCALE  = 64'd32767;
   localparam int              Q_FRAC      = 30;
   localparam int              TAYLOR_TERMS = 8;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_INCREMENT  = 3'd0,
      CSR_INCREMENT_STEP   = 3'd1,
      CSR_SAMPLES_PER_STEP = 3'd2,
      CSR_STEP_COUNT       = 3'd3,
      CSR_CHANNEL_MODE     = 3'd4,
      CSR_VOLUME           = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              neg;
      logic              zero;
      logic [STEP_W-1:0] step_index;
      logic              done;
   } sweep_info_type;

   typedef struct packed {
      logic [MODE_W-1:0]   channel_mode;
      logic [VOLUME_W-1:0] volume;
   } scale_cfg_type;

   // q30 taylor series of sin, scaled to full scale and rounded half up
   function automatic logic [MAG_W-1:0] sine_q15(input longint unsigned angle);
      longint unsigned term;
      longint unsigned plus;
      longint unsigned minus;
      longint unsigned s;
      longint unsigned v;
      term  = angle;
      plus  = angle;
      minus = 64'd0;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         term = (term * angle) >> Q_FRAC;
         term = (term * angle) >> Q_FRAC;
         term = term / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            minus = minus + term;
         end else begin
            plus = plus + term;
         end
      end
      s = (plus >= minus) ? plus - minus : 64'd0;
      v = (s * FULL_SCALE + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
      if (v > FULL_SCALE) begin
         v = FULL_SCALE;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

// ----- hdl/ssg_if.sv -----
// channel interfaces of the stepped sine sweep generator
`timescale 1ns / 1ps

interface ssg_req_if import ssg_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface ssg_rsp_if import ssg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic [STEP_W-1:0]          step_index;
   logic                       sweep_done;
   modport source (output valid, output left_sample, output right_sample,
                   output step_index, output sweep_done, input ready);
   modport sink (input valid, input left_sample, input right_sample,
                 input step_index, input sweep_done, output ready);
endinterface

interface ssg_csr_if import ssg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- hdl/ssg_sequencer.sv -----
// control registers, sweep state and sine table address generation
`timescale 1ns / 1ps

module ssg_sequencer import ssg_pkg::*; #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024,
   localparam int ADDR_BITS       = $clog2(SINE_TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   ssg_csr_if.sink            csr_ch,
   input  logic               take,
   input  logic               restart,
   output logic [ADDR_BITS:0] rom_addr,
   output sweep_info_type     info,
   output scale_cfg_type      scale_cfg
);

   logic [INCR_W-1:0]     start_inc_ff;
   logic [INCR_W-1:0]     inc_step_ff;
   logic [COUNT_W-1:0]    per_step_ff;
   logic [STEP_W-1:0]     step_count_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [VOLUME_W-1:0]   volume_ff;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [INCR_W-1:0]     incr_ff, incr_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  fin_ff, fin_in;

   logic [PHASE_BITS-1:0] eff_phase;
   logic [INCR_W-1:0]     eff_incr;
   logic [COUNT_W-1:0]    eff_cnt;
   logic [STEP_W-1:0]     eff_step;
   logic                  eff_fin;

   logic [ADDR_BITS+1:0]  pos;
   logic [1:0]            quad;
   logic [ADDR_BITS-1:0]  off;
   logic [PHASE_BITS-1:0] phase_sum;
   logic [COUNT_W-1:0]    cnt_inc;
   logic [COUNT_W-1:0]    per_eff;
   logic [STEP_W-1:0]     steps_eff;
   logic                  step_end;
   logic                  last_step;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_inc_ff  <= '0;
         inc_step_ff   <= '0;
         per_step_ff   <= SAMPLES_PER_STEP_RESET;
         step_count_ff <= STEP_COUNT_RESET;
         mode_ff       <= '0;
         volume_ff     <= VOLUME_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.addr))
            CSR_START_INCREMENT:  start_inc_ff  <= csr_ch.data[INCR_W-1:0];
            CSR_INCREMENT_STEP:   inc_step_ff   <= csr_ch.data[INCR_W-1:0];
            CSR_SAMPLES_PER_STEP: per_step_ff   <= csr_ch.data[COUNT_W-1:0];
            CSR_STEP_COUNT:       step_count_ff <= csr_ch.data[STEP_W-1:0];
            CSR_CHANNEL_MODE:     mode_ff       <= csr_ch.data[MODE_W-1:0];
            CSR_VOLUME:           volume_ff     <= csr_ch.data[VOLUME_W-1:0];
            default: ;
         endcase
      end
   end

   // restart takes effect before the sample of the same transfer
   always_comb begin
      eff_phase = restart ? '0 : phase_ff;
      eff_incr  = restart ? start_inc_ff : incr_ff;
      eff_cnt   = restart ? '0 : cnt_ff;
      eff_step  = restart ? '0 : step_ff;
      eff_fin   = restart ? 1'b0 : fin_ff;
   end

   always_comb begin
      pos      = eff_phase[PHASE_BITS-1 -: ADDR_BITS+2];
      quad     = pos[ADDR_BITS+1:ADDR_BITS];
      off      = pos[ADDR_BITS-1:0];
      rom_addr = quad[0] ? (ADDR_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, off} : {1'b0, off};
   end

   always_comb begin
      phase_sum = eff_phase + PHASE_BITS'(eff_incr);
      cnt_inc   = eff_cnt + COUNT_W'(1);
      per_eff   = (per_step_ff == '0) ? COUNT_W'(1) : per_step_ff;
      steps_eff = (step_count_ff == '0) ? STEP_W'(1) : step_count_ff;
      step_end  = (cnt_inc >= per_eff) || (cnt_inc == '0);
      last_step = ({1'b0, eff_step} + (STEP_W+1)'(1)) >= {1'b0, steps_eff};
   end

   always_comb begin
      phase_in = phase_ff;
      incr_in  = incr_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      fin_in   = fin_ff;
      if (take) begin
         phase_in = eff_phase;
         incr_in  = eff_incr;
         cnt_in   = eff_cnt;
         step_in  = eff_step;
         fin_in   = eff_fin;
         if (!eff_fin) begin
            phase_in = step_end ? '0 : phase_sum;
            cnt_in   = step_end ? '0 : cnt_inc;
            if (step_end) begin
               if (last_step) begin
                  fin_in = 1'b1;
               end else begin
                  step_in = eff_step + STEP_W'(1);
                  incr_in = eff_incr + inc_step_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         incr_ff  <= '0;
         cnt_ff   <= '0;
         step_ff  <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         incr_ff  <= incr_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      info.neg        = quad[1];
      info.zero       = eff_fin;
      info.step_index = eff_step;
      info.done       = eff_fin | (step_end & last_step);
      scale_cfg.channel_mode = mode_ff;
      scale_cfg.volume       = volume_ff;
   end

endmodule

// ----- hdl/ssg_sine_rom.sv -----
// quarter-wave sine table with registered read
`timescale 1ns / 1ps

module ssg_sine_rom import ssg_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024,
   localparam int ADDR_BITS       = $clog2(SINE_TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               read_en,
   input  logic [ADDR_BITS:0] addr,
   output logic [MAG_W-1:0]   data
);

   logic [MAG_W-1:0] rom_mem [0:SINE_TABLE_DEPTH];

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_entry
      localparam longint unsigned ANGLE =
         (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      assign rom_mem[i] = sine_q15(ANGLE);
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         data <= rom_mem[addr];
      end
   end

endmodule

// ----- hdl/ssg_scaler.sv -----
// volume scaling pipeline and result register
`timescale 1ns / 1ps

module ssg_scaler import ssg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  sweep_info_type info,
   input  scale_cfg_type  scale_cfg,
   input  logic [MAG_W-1:0] rom_data,
   output logic           in_ready,
   ssg_rsp_if.source      rsp_ch
);

   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   logic                 v3_ff, v3_in;
   logic                 en1, en2, en3;
   sweep_info_type       info1_ff;
   sweep_info_type       info2_ff;
   logic [PRODUCT_W-1:0] prod2_ff;

   logic [MAG_W-1:0]          q0;
   logic [MAG_W:0]            rem;
   logic [MAG_W-1:0]          quot;
   logic signed [SAMPLE_W-1:0] mag;
   logic signed [SAMPLE_W-1:0] val;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;

   always_comb begin
      en3      = !v3_ff || rsp_ch.ready;
      en2      = !v2_ff || en3;
      en1      = !v1_ff || en2;
      in_ready = en1;
      v1_in    = en1 ? take : v1_ff;
      v2_in    = en2 ? v1_ff : v2_ff;
      v3_in    = en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         info1_ff <= info;
      end
      if (en2) begin
         info2_ff <= info1_ff;
         prod2_ff <= PRODUCT_W'(scale_cfg.volume) * PRODUCT_W'(rom_data);
      end
   end

   // divide by full scale: shift estimate plus one correction
   always_comb begin
      q0   = prod2_ff[PRODUCT_W-1:MAG_W];
      rem  = {1'b0, prod2_ff[MAG_W-1:0]} + {1'b0, q0};
      quot = (rem >= (MAG_W+1)'(FULL_SCALE)) ? q0 + MAG_W'(1) : q0;
      mag  = signed'({1'b0, quot});
      val  = info2_ff.neg ? -mag : mag;
      if (info2_ff.zero) begin
         val = '0;
      end
      left_in  = scale_cfg.channel_mode[MUTE_LEFT_BIT] ? '0 : val;
      right_in = scale_cfg.channel_mode[MUTE_RIGHT_BIT] ? '0 : val;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_ch.left_sample  <= left_in;
         rsp_ch.right_sample <= right_in;
         rsp_ch.step_index   <= info2_ff.step_index;
         rsp_ch.sweep_done   <= info2_ff.done;
      end
   end

   assign rsp_ch.valid = v3_ff;

endmodule

// ----- hdl/stepped_sine_sweep_generator.sv -----
// top level of the stepped sine sweep generator
//
//   channel   direction   handshake      payload
//   req_ch    in          valid/ready    restart
//   rsp_ch    out         valid/ready    left_sample, right_sample, step_index, sweep_done
//   csr_ch    in          valid/ready    addr (register index), data
//
// one sample pair per cycle while the result channel does not stall; a result passes the table read,
// volume multiply, then divide and output register
// the sweep state updates at the input transfer, so sample n+1 can enter the cycle after n
// synchronous reset clears the sweep and restores the register defaults
// a stalled result holds the output register; up to two more items enter behind it
`timescale 1ns / 1ps

module stepped_sine_sweep_generator import ssg_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input logic       clock,
   input logic       reset,
   ssg_req_if.sink   req_ch,
   ssg_rsp_if.source rsp_ch,
   ssg_csr_if.sink   csr_ch
);

   localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

   logic               in_ready;
   logic               take;
   logic [ADDR_BITS:0] rom_addr;
   logic [MAG_W-1:0]   rom_data;
   sweep_info_type     info;
   scale_cfg_type      scale_cfg;

   assign req_ch.ready = in_ready;
   assign take         = req_ch.valid & in_ready;

   ssg_sequencer #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .take      (take),
      .restart   (req_ch.restart),
      .rom_addr  (rom_addr),
      .info      (info),
      .scale_cfg (scale_cfg)
   );

   ssg_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock   (clock),
      .read_en (in_ready),
      .addr    (rom_addr),
      .data    (rom_data)
   );

   ssg_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .info      (info),
      .scale_cfg (scale_cfg),
      .rom_data  (rom_data),
      .in_ready  (in_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- hdl/ssg_checker.sv -----
// port level checks of the stepped sine sweep generator and their binding
`timescale 1ns / 1ps

module ssg_checker import ssg_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] left_sample,
   input logic signed [SAMPLE_W-1:0] right_sample
);

   logic [2:0] count_ff, count_in;

   // items accepted but not yet transferred out
   always_comb begin
      count_in = count_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_sample) && $stable(right_sample))
      else $error("result changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("result with no item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd3)
      else $error("more items in flight than pipeline stages");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> left_sample != 16'sh8000 && right_sample != 16'sh8000)
      else $error("sample beyond full scale");

endmodule

bind stepped_sine_sweep_generator ssg_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .left_sample  (rsp_ch.left_sample),
   .right_sample (rsp_ch.right_sample)
);

// ----- test/stepped_sine_sweep_generator_tb.sv -----
// testbench for the stepped sine sweep generator: random stimulus checked against a sweep predictor
`timescale 1ns / 1ps

module stepped_sine_sweep_generator_tb import ssg_pkg::*; ();

   localparam int                    QUARTER_DEPTH   = 1024;
   localparam longint unsigned       HALF_PI_FIXED   = 64'd1686629713;
   localparam longint unsigned       PEAK_CODE       = 64'd32767;
   localparam int                    FRACTION_BITS   = 30;
   localparam int                    SERIES_TERMS    = 8;
   localparam int                    DRAIN_CYCLES    = 8;
   localparam int                    QUIET_LIMIT     = 2000;
   localparam int                    RANDOM_ITEMS    = 1950;
   localparam int                    CALM_FROM       = 1700;
   localparam int                    REPORT_LIMIT    = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic [STEP_W-1:0]          step_index;
      logic                       sweep_done;
   } sample_pair_type;

   logic clock;
   logic reset;

   ssg_req_if req_ch ();
   ssg_rsp_if rsp_ch ();
   ssg_csr_if csr_ch ();

   stepped_sine_sweep_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [MAG_W-1:0] quarter_wave [0:QUARTER_DEPTH];

   logic [INCR_W-1:0]   cfg_start_increment;
   logic [INCR_W-1:0]   cfg_increment_step;
   logic [COUNT_W-1:0]  cfg_samples_per_step;
   logic [STEP_W-1:0]   cfg_step_count;
   logic [MODE_W-1:0]   cfg_channel_mode;
   logic [VOLUME_W-1:0] cfg_volume;

   logic [INCR_W-1:0]  sweep_phase;
   logic [INCR_W-1:0]  sweep_increment;
   logic [COUNT_W-1:0] sweep_in_step;
   logic [STEP_W-1:0]  sweep_step;
   logic               sweep_finished;

   logic            pending_restarts [$];
   sample_pair_type expected_pairs [$];

   int  mismatches;
   int  quiet_cycles;
   int  gap_left;
   int  stall_left;
   bit  calm;

   function automatic logic [MAG_W-1:0] taylor_sine_point(input int unsigned index);
      longint unsigned x;
      longint unsigned term;
      longint unsigned pos_sum;
      longint unsigned neg_sum;
      longint unsigned net;
      longint unsigned scaled;
      x = (HALF_PI_FIXED * index) / QUARTER_DEPTH;
      term = x;
      pos_sum = x;
      neg_sum = 0;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = (term * x) >> FRACTION_BITS;
         term = ((term * x) >> FRACTION_BITS) / longint'(2 * k * (2 * k + 1));
         if (k % 2 == 1) begin
            neg_sum = neg_sum + term;
         end else begin
            pos_sum = pos_sum + term;
         end
      end
      net = (pos_sum >= neg_sum) ? pos_sum - neg_sum : 64'd0;
      scaled = (net * PEAK_CODE + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      if (scaled > PEAK_CODE) begin
         scaled = PEAK_CODE;
      end
      return scaled[MAG_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pad_upper(input logic [CSR_DATA_W-1:0] value,
                                                       input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (width >= CSR_DATA_W) ? '1 : ((32'd1 << width) - 32'd1);
      if ($urandom_range(0, 3) == 0) begin
         return (value & mask) | ($urandom() & ~mask);
      end
      return value & mask;
   endfunction

   task automatic apply_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_START_INCREMENT: begin
            cfg_start_increment = value[INCR_W-1:0];
         end
         CSR_INCREMENT_STEP: begin
            cfg_increment_step = value[INCR_W-1:0];
         end
         CSR_SAMPLES_PER_STEP: begin
            cfg_samples_per_step = value[COUNT_W-1:0];
         end
         CSR_STEP_COUNT: begin
            cfg_step_count = value[STEP_W-1:0];
         end
         CSR_CHANNEL_MODE: begin
            cfg_channel_mode = value[MODE_W-1:0];
         end
         CSR_VOLUME: begin
            cfg_volume = value[VOLUME_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic advance_sweep(input logic restart_bit);
      logic [COUNT_W-1:0]   per_step;
      logic [STEP_W-1:0]    steps;
      logic [11:0]          position;
      logic [MAG_W-1:0]     magnitude;
      logic [PRODUCT_W-1:0] product;
      logic [SAMPLE_W-1:0]  level;
      sample_pair_type      pair;
      per_step = (cfg_samples_per_step == '0) ? COUNT_W'(1) : cfg_samples_per_step;
      steps = (cfg_step_count == '0) ? STEP_W'(1) : cfg_step_count;
      if (restart_bit) begin
         sweep_phase = '0;
         sweep_increment = cfg_start_increment;
         sweep_in_step = '0;
         sweep_step = '0;
         sweep_finished = 1'b0;
      end
      pair.step_index = sweep_step;
      if (sweep_finished) begin
         pair.left_sample = '0;
         pair.right_sample = '0;
         pair.sweep_done = 1'b1;
      end else begin
         position = sweep_phase[INCR_W-1:INCR_W-12];
         if (position[10]) begin
            magnitude = quarter_wave[QUARTER_DEPTH - int'(position[9:0])];
         end else begin
            magnitude = quarter_wave[position[9:0]];
         end
         product = cfg_volume * magnitude;
         level = SAMPLE_W'(product / PRODUCT_W'(32767));
         if (position[11]) begin
            level = -level;
         end
         pair.left_sample = cfg_channel_mode[MUTE_LEFT_BIT] ? '0 : level;
         pair.right_sample = cfg_channel_mode[MUTE_RIGHT_BIT] ? '0 : level;
         pair.sweep_done = 1'b0;
         sweep_phase = sweep_phase + sweep_increment;
         sweep_in_step = sweep_in_step + 1'b1;
         if (sweep_in_step >= per_step || sweep_in_step == '0) begin
            sweep_in_step = '0;
            sweep_phase = '0;
            if (int'(sweep_step) + 1 >= int'(steps)) begin
               sweep_finished = 1'b1;
               pair.sweep_done = 1'b1;
            end else begin
               sweep_step = sweep_step + 1'b1;
               sweep_increment = sweep_increment + cfg_increment_step;
            end
         end
      end
      expected_pairs.push_back(pair);
   endtask

   task automatic report_mismatch(input string what, input sample_pair_type want,
                                  input sample_pair_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t %s: expected left %0d right %0d step %0d done %0d,",
                  $realtime, what, $signed(want.left_sample), $signed(want.right_sample),
                  want.step_index, want.sweep_done);
         $display("   got left %0d right %0d step %0d done %0d",
                  $signed(got.left_sample), $signed(got.right_sample), got.step_index,
                  got.sweep_done);
      end
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= index;
      csr_ch.data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      apply_register(index, value);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_sweep();
      while (pending_restarts.size() > 0 || req_ch.valid || expected_pairs.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_items(input int count, input bit restart_first, input int restart_odds);
      for (int i = 0; i < count; i++) begin
         if (i == 0 && restart_first) begin
            pending_restarts.push_back(1'b1);
         end else if (restart_odds > 0 && $urandom_range(1, restart_odds) == 1) begin
            pending_restarts.push_back(1'b1);
         end else begin
            pending_restarts.push_back(1'b0);
         end
      end
      drain_sweep();
   endtask

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.restart <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            advance_sweep(req_ch.restart);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_restarts.size() > 0) begin
               if (!calm && $urandom_range(0, 9) == 0) begin
                  gap_left = $urandom_range(1, 6) - 1;
                  req_ch.valid <= 1'b0;
               end else begin
                  req_ch.valid <= 1'b1;
                  req_ch.restart <= pending_restarts.pop_front();
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      sample_pair_type got;
      sample_pair_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.left_sample = rsp_ch.left_sample;
            got.right_sample = rsp_ch.right_sample;
            got.step_index = rsp_ch.step_index;
            got.sweep_done = rsp_ch.sweep_done;
            if (expected_pairs.size() == 0) begin
               report_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_pairs.pop_front();
               if (got !== want) begin
                  report_mismatch("mismatch", want, got);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                    random_items;
      int                    count;
      longint                sweep_length;
      logic [CSR_DATA_W-1:0] value;
      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.data = '0;
      for (int i = 0; i <= QUARTER_DEPTH; i++) begin
         quarter_wave[i] = taylor_sine_point(i);
      end
      cfg_start_increment = '0;
      cfg_increment_step = '0;
      cfg_samples_per_step = SAMPLES_PER_STEP_RESET;
      cfg_step_count = STEP_COUNT_RESET;
      cfg_channel_mode = '0;
      cfg_volume = VOLUME_RESET;
      sweep_phase = '0;
      sweep_increment = '0;
      sweep_in_step = '0;
      sweep_step = '0;
      sweep_finished = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults after reset
      run_items(3, 1'b0, 0);

      // quarter-turn increment walks all four quadrants at full volume
      write_register(CSR_START_INCREMENT, 32'h4000_0000);
      write_register(CSR_INCREMENT_STEP, 32'h8000_0000);
      write_register(CSR_SAMPLES_PER_STEP, 32'd4);
      write_register(CSR_STEP_COUNT, 32'd2);
      write_register(CSR_CHANNEL_MODE, 32'd0);
      write_register(CSR_VOLUME, 32'h0000_7FFF);
      write_register(CSR_UNMAPPED_LO, 32'hFFFF_FFFF);
      write_register(CSR_UNMAPPED_HI, 32'hFFFF_FFFF);
      run_items(1, 1'b0, 0);
      run_items(10, 1'b1, 0);

      // zero counts, both channels muted, silent volume
      write_register(CSR_VOLUME, 32'd0);
      write_register(CSR_CHANNEL_MODE, 32'd3);
      write_register(CSR_SAMPLES_PER_STEP, 32'd0);
      write_register(CSR_STEP_COUNT, 32'd0);
      run_items(3, 1'b1, 0);

      // increment wrap, left only, then step count lowered mid sweep
      write_register(CSR_START_INCREMENT, 32'hFFFF_FFF0);
      write_register(CSR_INCREMENT_STEP, 32'h7FFF_FFFF);
      write_register(CSR_SAMPLES_PER_STEP, 32'd2);
      write_register(CSR_STEP_COUNT, 32'd3);
      write_register(CSR_CHANNEL_MODE, 32'd1);
      write_register(CSR_VOLUME, 32'd12345);
      run_items(4, 1'b1, 0);
      write_register(CSR_CHANNEL_MODE, 32'd2);
      write_register(CSR_STEP_COUNT, 32'd1);
      run_items(4, 1'b0, 0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= CALM_FROM) begin
            calm = 1'b1;
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: value = 32'd0;
               1: value = 32'hFFFF_FFFF;
               2: value = $urandom_range(0, 32'h00FF_FFFF);
               default: value = $urandom();
            endcase
            write_register(CSR_START_INCREMENT, value);
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 6))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'd0;
               3: value = $urandom_range(0, 32'h00FF_FFFF);
               4: value = -$urandom_range(0, 32'h00FF_FFFF);
               default: value = $urandom();
            endcase
            write_register(CSR_INCREMENT_STEP, value);
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 15))
               0: value = 32'd0;
               1: value = 32'h00FF_FFFF;
               2: value = $urandom();
               default: value = $urandom_range(1, 12);
            endcase
            write_register(CSR_SAMPLES_PER_STEP, pad_upper(value, COUNT_W));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 15))
               0: value = 32'd0;
               1: value = 32'h0000_FFFF;
               2: value = $urandom();
               default: value = $urandom_range(1, 8);
            endcase
            write_register(CSR_STEP_COUNT, pad_upper(value, STEP_W));
         end
         if ($urandom_range(0, 1)) begin
            write_register(CSR_CHANNEL_MODE, pad_upper($urandom_range(0, 3), MODE_W));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: value = 32'd0;
               1: value = 32'h0000_7FFF;
               default: value = $urandom_range(0, 32767);
            endcase
            write_register(CSR_VOLUME, pad_upper(value, VOLUME_W));
         end
         sweep_length = longint'((cfg_samples_per_step == '0) ? 1 : cfg_samples_per_step) *
                        longint'((cfg_step_count == '0) ? 1 : cfg_step_count);
         count = (sweep_length > 60) ? 60 : int'(sweep_length);
         count = count + $urandom_range(0, 4);
         run_items(count, $urandom_range(0, 3) != 0, 50);
         random_items = random_items + count;
      end

      drain_sweep();
      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
